FILE: src/clcd4_pkg.sv
// Shared types, codes and constants for the four-bit character LCD sequencer.
package clcd4_pkg;

	// Command codes
	localparam logic [2:0] CMD_INIT   = 3'd0;
	localparam logic [2:0] CMD_CLEAR  = 3'd1;
	localparam logic [2:0] CMD_CURSOR = 3'd2;
	localparam logic [2:0] CMD_DATA   = 3'd3;
	localparam logic [2:0] CMD_INSTR  = 3'd4;
	localparam logic [2:0] CMD_GLYPH  = 3'd5;

	// Fixed instruction bytes
	localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
	localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
	localparam logic [7:0] BYTE_CLEAR    = 8'h01;
	localparam logic [7:0] BYTE_DDRAM    = 8'h80;
	localparam logic [7:0] BYTE_LINE2    = 8'h40;
	localparam logic [7:0] BYTE_CGRAM    = 8'h40;

	// Reset-sequence nibbles
	localparam logic [3:0] NIB_WAKE  = 4'h3;
	localparam logic [3:0] NIB_4BIT  = 4'h2;
	localparam logic [3:0] NIB_ZERO  = 4'h0;

	// Hold times in microseconds
	localparam logic [17:0] WAIT_EN_HIGH   = 18'd150;
	localparam logic [17:0] WAIT_HIGH_NIB  = 18'd300;
	localparam logic [17:0] WAIT_LOW_NIB   = 18'd2200;
	localparam logic [17:0] WAIT_CLEAR     = 18'd7200;
	localparam logic [17:0] WAIT_POWER_UP  = 18'd150000;
	localparam logic [17:0] WAIT_WAKE_1    = 18'd5200;
	localparam logic [17:0] WAIT_WAKE_2    = 18'd1200;
	localparam logic [17:0] WAIT_EN_LOW    = 18'd200;

	// Which byte the datapath sends
	typedef enum logic [1:0] {
		BSEL_HELD,
		BSEL_FSET,
		BSEL_DISP,
		BSEL_CLEAR
	} bsel_t;

	// Kind of step being generated
	typedef enum logic [1:0] {
		STEP_PWR,
		STEP_INIT,
		STEP_BYTE
	} kind_t;

	// Controller to datapath
	typedef struct packed {
		logic        capture;
		logic        load;
		kind_t       kind;
		logic [1:0]  nib_idx;
		bsel_t       bsel;
		logic        half;
		logic        en_low;
		logic        last;
	} dp_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic adv;
	} dp_stat_t;

	// DDRAM row offsets for the four-line layout
	function automatic logic [7:0] row_base_4l(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			2'd3: b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Enable-low hold of each reset-sequence nibble
	function automatic logic [17:0] wake_wait(input logic [1:0] idx);
		logic [17:0] w;
		unique case (idx)
			2'd0: w = WAIT_WAKE_1;
			2'd1: w = WAIT_WAKE_2;
			default: w = WAIT_EN_LOW;
		endcase
		return w;
	endfunction

endpackage

FILE: src/clcd4_ctrl.sv
// Sequencer state machine: walks the step order of each command.
module clcd4_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  clcd4_pkg::dp_stat_t stat,
	output clcd4_pkg::dp_ctl_t  ctl
);
	import clcd4_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PWR  = 4'b0010,
		ST_NIB  = 4'b0100,
		ST_BYTE = 4'b1000
	} state_t;

	state_t     state_q;
	logic [1:0] nib_idx_q;
	logic [1:0] byte_idx_q;
	logic       half_q;
	logic       ph_q;
	logic       init_q;
	logic       clr_q;
	logic       final_byte;
	logic       busy;

	assign busy       = (state_q != ST_IDLE);
	assign in_stall   = busy;
	assign final_byte = !init_q || (byte_idx_q == 2'd2);

	always_comb begin
		ctl.capture = !busy && in_valid;
		ctl.load    = busy && stat.adv;
		ctl.nib_idx = nib_idx_q;
		ctl.half    = half_q;
		ctl.en_low  = ph_q;
		ctl.last    = (state_q == ST_BYTE) && half_q && ph_q && final_byte;
		unique case (state_q)
			ST_PWR:  ctl.kind = STEP_PWR;
			ST_NIB:  ctl.kind = STEP_INIT;
			default: ctl.kind = STEP_BYTE;
		endcase
		if (init_q) begin
			unique case (byte_idx_q)
				2'd0:    ctl.bsel = BSEL_FSET;
				2'd1:    ctl.bsel = BSEL_DISP;
				default: ctl.bsel = BSEL_CLEAR;
			endcase
		end else if (clr_q) begin
			ctl.bsel = BSEL_CLEAR;
		end else begin
			ctl.bsel = BSEL_HELD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nib_idx_q  <= 2'd0;
			byte_idx_q <= 2'd0;
			half_q     <= 1'b0;
			ph_q       <= 1'b0;
			init_q     <= 1'b0;
			clr_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					nib_idx_q  <= 2'd0;
					byte_idx_q <= 2'd0;
					half_q     <= 1'b0;
					ph_q       <= 1'b0;
					if (in_valid) begin
						init_q <= (command == CMD_INIT);
						clr_q  <= (command == CMD_CLEAR);
						if (command == CMD_INIT) begin
							state_q <= ST_PWR;
						end else if (command <= CMD_GLYPH) begin
							state_q <= ST_BYTE;
						end
					end
				end
				ST_PWR: begin
					if (stat.adv) begin
						state_q <= ST_NIB;
					end
				end
				ST_NIB: begin
					if (stat.adv) begin
						ph_q <= !ph_q;
						if (ph_q) begin
							nib_idx_q <= nib_idx_q + 2'd1;
							if (nib_idx_q == 2'd3) begin
								state_q <= ST_BYTE;
							end
						end
					end
				end
				ST_BYTE: begin
					if (stat.adv) begin
						ph_q <= !ph_q;
						if (ph_q) begin
							half_q <= !half_q;
							if (half_q) begin
								byte_idx_q <= byte_idx_q + 2'd1;
								if (final_byte) begin
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: src/clcd4_dp.sv
// Datapath: byte capture, address arithmetic, step fields and output register.
module clcd4_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic [2:0]          command,
	input  logic [7:0]          data_byte,
	input  logic [1:0]          row,
	input  logic [5:0]          column,
	input  logic [2:0]          glyph_slot,
	input  clcd4_pkg::dp_ctl_t  ctl,
	output clcd4_pkg::dp_stat_t stat,
	input  logic                out_stall,
	output logic                out_valid,
	output logic                register_select,
	output logic [3:0]          nibble,
	output logic                enable,
	output logic [17:0]         wait_us,
	output logic                last
);
	import clcd4_pkg::*;

	logic        display_type_q;
	logic [7:0]  byte_q;
	logic        rs_hold_q;
	logic [7:0]  row_base;
	logic [7:0]  byte_next;
	logic [7:0]  cur_byte;
	logic        step_rs;
	logic [3:0]  step_nib;
	logic        step_en;
	logic [17:0] step_wait;
	logic        out_valid_q;
	logic        rs_q;
	logic [3:0]  nib_q;
	logic        en_q;
	logic [17:0] wait_q;
	logic        last_q;

	// Byte captured with the command
	always_comb begin
		if (display_type_q) begin
			row_base = row_base_4l(row);
		end else begin
			row_base = (row == 2'd0) ? 8'h00 : BYTE_LINE2;
		end
		unique case (command)
			CMD_CURSOR: byte_next = BYTE_DDRAM + row_base + {2'b00, column};
			CMD_GLYPH:  byte_next = BYTE_CGRAM | {2'b00, glyph_slot, 3'b000};
			default:    byte_next = data_byte;
		endcase
	end

	always_comb begin
		unique case (ctl.bsel)
			BSEL_FSET:  cur_byte = BYTE_FUNC_SET;
			BSEL_DISP:  cur_byte = BYTE_DISP_ON;
			BSEL_CLEAR: cur_byte = BYTE_CLEAR;
			default:    cur_byte = byte_q;
		endcase
		step_en = !ctl.en_low;
		unique case (ctl.kind)
			STEP_PWR: begin
				step_rs   = 1'b0;
				step_nib  = NIB_ZERO;
				step_en   = 1'b0;
				step_wait = WAIT_POWER_UP;
			end
			STEP_INIT: begin
				step_rs   = 1'b0;
				step_nib  = (ctl.nib_idx == 2'd3) ? NIB_4BIT : NIB_WAKE;
				step_wait = ctl.en_low ? wake_wait(ctl.nib_idx) : WAIT_EN_HIGH;
			end
			default: begin
				step_rs  = (ctl.bsel == BSEL_HELD) ? rs_hold_q : 1'b0;
				step_nib = ctl.half ? cur_byte[3:0] : cur_byte[7:4];
				if (!ctl.en_low) begin
					step_wait = WAIT_EN_HIGH;
				end else if (!ctl.half) begin
					step_wait = WAIT_HIGH_NIB;
				end else if (ctl.bsel == BSEL_CLEAR) begin
					step_wait = WAIT_CLEAR;
				end else begin
					step_wait = WAIT_LOW_NIB;
				end
			end
		endcase
	end

	assign stat.adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_type_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				display_type_q <= cfg_wdata;
			end
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			byte_q    <= byte_next;
			rs_hold_q <= (command == CMD_DATA);
		end
		if (ctl.load) begin
			rs_q   <= step_rs;
			nib_q  <= step_nib;
			en_q   <= step_en;
			wait_q <= step_wait;
			last_q <= ctl.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign register_select = rs_q;
	assign nibble          = nib_q;
	assign enable          = en_q;
	assign wait_us         = wait_q;
	assign last            = last_q;

endmodule

FILE: src/char_lcd_4bit_interface_sequencer_core.sv
// Top level of the four-bit character LCD sequencer: controller plus datapath.
//
// Each accepted command becomes a run of pin-level steps (RS, D7..D4, E, hold
// time in us, last mark), one step per transfer on the output side. The
// state machine emits at most one step per clock and none while the output
// register holds a stalled step. A run has 21 steps for init (power-up
// wait, four reset nibbles, then function set, display on and a clear) and
// 4 steps for commands 1 to 5. The input is stalled while a run is in
// progress; it reopens the cycle after the last step enters the output
// register, so a new command can be taken while that step still waits.
// Commands 6 and 7 are taken and produce nothing. Output stall simply
// freezes the sequencer. The display_type register (0: 16x2, 1: 20x4
// addressing) may be written only while no run is in progress; it resets
// to 16x2.
module char_lcd_4bit_interface_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// command channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	input  logic [2:0]  glyph_slot,
	// step channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        register_select,
	output logic [3:0]  nibble,
	output logic        enable,
	output logic [17:0] wait_us,
	output logic        last
);
	import clcd4_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// Step order and input handshake
	clcd4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Byte/address formation and the output register
	clcd4_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.command         (command),
		.data_byte       (data_byte),
		.row             (row),
		.column          (column),
		.glyph_slot      (glyph_slot),
		.ctl             (ctl),
		.stat            (stat),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.register_select (register_select),
		.nibble          (nibble),
		.enable          (enable),
		.wait_us         (wait_us),
		.last            (last)
	);

	// Every enable strobe is a 150 us high phase
	a_en_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable |-> wait_us == WAIT_EN_HIGH)
		else $error("enable-high step with wrong hold time");

	// A run always ends on an enable-low step
	a_last_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !enable)
		else $error("last step has enable high");

	// Init transfer starts a run
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == CMD_INIT |=> in_stall)
		else $error("init command did not start a run");

	// Unknown commands leave the input open; an earlier last step may still wait
	a_unknown_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command > CMD_GLYPH |=> !in_stall)
		else $error("unknown command started a run");

	// A run in progress with room at the output always issues a step
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && (!out_valid || !out_stall) |=> out_valid)
		else $error("sequencer stalled with free output");

endmodule
